// ===== src/sbpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpp_pkg: shared types and constants of the six-button pad poller
// Holds the poll phase encoding, the state and result records, the button
// bit layout and the pin decode tables of the gamepad.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  // Button word layout.
  localparam int unsigned BTN_W = 12;
  localparam logic [BTN_W-1:0] B_ON    = 12'h001;
  localparam logic [BTN_W-1:0] B_UP    = 12'h002;
  localparam logic [BTN_W-1:0] B_DOWN  = 12'h004;
  localparam logic [BTN_W-1:0] B_LEFT  = 12'h008;
  localparam logic [BTN_W-1:0] B_RIGHT = 12'h010;
  localparam logic [BTN_W-1:0] B_START = 12'h020;
  localparam logic [BTN_W-1:0] B_A     = 12'h040;
  localparam logic [BTN_W-1:0] B_B     = 12'h080;
  localparam logic [BTN_W-1:0] B_C     = 12'h100;
  localparam logic [BTN_W-1:0] B_X     = 12'h200;
  localparam logic [BTN_W-1:0] B_Y     = 12'h400;
  localparam logic [BTN_W-1:0] B_Z     = 12'h800;
  localparam logic [BTN_W-1:0] ARROW_MASK = 12'h01E;

  // Index value meaning no button remembered.
  localparam logic [3:0] NONE_IDX = 4'd15;

  // Register reset values.
  localparam logic [15:0] ARROW_REPEAT_RST  = 16'd80;
  localparam logic [15:0] ACTION_REPEAT_RST = 16'd150;

  // Register select codes (address bit 2).
  localparam logic REG_ARROW_REPEAT  = 1'b0;
  localparam logic REG_ACTION_REPEAT = 1'b1;

  // Poll phases. Codes 6 and 7 are treated as the first phase.
  typedef enum logic [2:0] {
    PH_LOW0       = 3'd0,
    PH_HIGH0      = 3'd1,
    PH_LOW1       = 3'd2,
    PH_HIGH1      = 3'd3,
    PH_PULSE_LOW  = 3'd4,
    PH_PULSE_HIGH = 3'd5
  } phase_t;

  // Poller state carried from one sample to the next.
  typedef struct packed {
    phase_t           phase;
    logic [BTN_W-1:0] accum;
    logic             six_mode;
    logic [BTN_W-1:0] prev;
    logic [3:0]       arrow_last;
    logic [31:0]      arrow_time;
    logic [3:0]       action_last;
    logic [31:0]      action_time;
  } state_t;

  // One result transaction.
  typedef struct packed {
    logic             select_level;
    logic             poll_done;
    logic [BTN_W-1:0] buttons;
    logic             changed;
    logic [BTN_W-1:0] just_pressed;
    logic [BTN_W-1:0] repeat_pressed;
    logic             six_mode;
  } result_t;

  // Select low: left or right pulled low means a pad is present.
  function automatic logic [BTN_W-1:0] decode_low(input logic [5:0] pins);
    logic [5:0] p;
    p = ~pins;
    return ({BTN_W{p[0]}} & B_UP) | ({BTN_W{p[1]}} & B_DOWN) |
           ({BTN_W{p[2] | p[3]}} & B_ON) | ({BTN_W{p[4]}} & B_A) |
           ({BTN_W{p[5]}} & B_START);
  endfunction

  // Select high: full direction pad plus B and C.
  function automatic logic [BTN_W-1:0] decode_high(input logic [5:0] pins);
    logic [5:0] p;
    p = ~pins;
    return ({BTN_W{p[0]}} & B_UP) | ({BTN_W{p[1]}} & B_DOWN) |
           ({BTN_W{p[2]}} & B_LEFT) | ({BTN_W{p[3]}} & B_RIGHT) |
           ({BTN_W{p[4]}} & B_B) | ({BTN_W{p[5]}} & B_C);
  endfunction

  // Extra high pulse of a six-button pad: X, Y and Z on the low pins.
  function automatic logic [BTN_W-1:0] decode_pulse(input logic [5:0] pins);
    logic [5:0] p;
    p = ~pins;
    return ({BTN_W{p[0]}} & B_Z) | ({BTN_W{p[1]}} & B_Y) | ({BTN_W{p[2]}} & B_X);
  endfunction

  // Mode decision after a low/high phase pair.
  function automatic logic mode_check(input logic [BTN_W-1:0] accum, input logic flag);
    logic f;
    f = flag;
    if (accum == (B_ON | B_UP | B_DOWN)) begin
      f = 1'b1;
    end else if ((accum & B_ON) == '0) begin
      f = 1'b0;
    end
    return f;
  endfunction

endpackage

// ===== src/sbpp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpp_step: next-state and result logic for one pad sample
// Decodes the pins for the current phase, advances the phase, decides the
// mode, and at the end of a poll forms the edge and auto-repeat bits.
// ----------------------------------------------------------------------------
module sbpp_step (
  input  logic [5:0]       pin_levels,
  input  logic [31:0]      now_ms,
  input  logic [15:0]      arrow_repeat_ms,
  input  logic [15:0]      action_repeat_ms,
  input  sbpp_pkg::state_t cur,
  output sbpp_pkg::state_t nxt,
  output sbpp_pkg::result_t res
);

  logic                        done;
  sbpp_pkg::phase_t            phase_next;
  logic [2:0]                  phase_bits;
  logic [sbpp_pkg::BTN_W-1:0]  accum_n;
  logic                        flag_n;
  logic [sbpp_pkg::BTN_W-1:0]  jp;
  logic [sbpp_pkg::BTN_W-1:0]  arrow_jp;
  logic [sbpp_pkg::BTN_W-1:0]  action_jp;
  logic [3:0]                  arrow_hi;
  logic [3:0]                  action_hi;
  logic [15:0]                 word16;
  logic [15:0]                 arrow_onehot;
  logic [15:0]                 action_onehot;
  logic [31:0]                 arrow_elapsed;
  logic [31:0]                 action_elapsed;
  logic                        arrow_hit;
  logic                        action_hit;
  logic [sbpp_pkg::BTN_W-1:0]  rp;

  // Poll end and phase sequencing.
  always_comb begin
    done       = 1'b0;
    phase_next = sbpp_pkg::PH_HIGH0;
    unique case (cur.phase)
      sbpp_pkg::PH_LOW0: begin
        phase_next = sbpp_pkg::PH_HIGH0;
      end
      sbpp_pkg::PH_HIGH0: begin
        done       = ~cur.six_mode;
        phase_next = cur.six_mode ? sbpp_pkg::PH_LOW1 : sbpp_pkg::PH_LOW0;
      end
      sbpp_pkg::PH_LOW1: begin
        phase_next = sbpp_pkg::PH_HIGH1;
      end
      sbpp_pkg::PH_HIGH1: begin
        phase_next = sbpp_pkg::PH_PULSE_LOW;
      end
      sbpp_pkg::PH_PULSE_LOW: begin
        phase_next = sbpp_pkg::PH_PULSE_HIGH;
      end
      sbpp_pkg::PH_PULSE_HIGH: begin
        done       = 1'b1;
        phase_next = sbpp_pkg::PH_LOW0;
      end
      default: begin
        phase_next = sbpp_pkg::PH_HIGH0;
      end
    endcase
  end

  assign phase_bits = 3'(phase_next);

  // Pin decode into the accumulated word and the mode decision.
  always_comb begin
    accum_n = cur.accum;
    flag_n  = cur.six_mode;
    unique case (cur.phase)
      sbpp_pkg::PH_LOW0, sbpp_pkg::PH_LOW1: begin
        accum_n = cur.accum | sbpp_pkg::decode_low(pin_levels);
      end
      sbpp_pkg::PH_HIGH0, sbpp_pkg::PH_HIGH1: begin
        accum_n = cur.accum | sbpp_pkg::decode_high(pin_levels);
        flag_n  = sbpp_pkg::mode_check(accum_n, cur.six_mode);
      end
      sbpp_pkg::PH_PULSE_LOW: begin
        accum_n = cur.accum;
      end
      sbpp_pkg::PH_PULSE_HIGH: begin
        accum_n = cur.accum | sbpp_pkg::decode_pulse(pin_levels);
      end
      default: begin
        accum_n = cur.accum | sbpp_pkg::decode_low(pin_levels);
      end
    endcase
  end

  // Newly pressed bits, split by class, and the highest index of each class.
  assign jp        = accum_n & ~cur.prev;
  assign arrow_jp  = jp & sbpp_pkg::ARROW_MASK;
  assign action_jp = jp & ~sbpp_pkg::ARROW_MASK;

  always_comb begin
    arrow_hi  = sbpp_pkg::NONE_IDX;
    action_hi = sbpp_pkg::NONE_IDX;
    for (int i = 0; i < sbpp_pkg::BTN_W; i++) begin
      if (arrow_jp[i]) begin
        arrow_hi = 4'(i);
      end
      if (action_jp[i]) begin
        action_hi = 4'(i);
      end
    end
  end

  // Auto-repeat: only the remembered button of a class can repeat, and not
  // in a poll where that class saw a new press (its time restarts at now).
  assign word16         = {4'b0, accum_n};
  assign arrow_elapsed  = now_ms - cur.arrow_time;
  assign action_elapsed = now_ms - cur.action_time;
  assign arrow_hit  = done && (arrow_jp == '0) && word16[cur.arrow_last] &&
                      (arrow_elapsed > {16'b0, arrow_repeat_ms});
  assign action_hit = done && (action_jp == '0) && word16[cur.action_last] &&
                      (action_elapsed > {16'b0, action_repeat_ms});
  assign arrow_onehot  = 16'b1 << cur.arrow_last;
  assign action_onehot = 16'b1 << cur.action_last;
  assign rp = (arrow_hit ? arrow_onehot[sbpp_pkg::BTN_W-1:0] : '0) |
              (action_hit ? action_onehot[sbpp_pkg::BTN_W-1:0] : '0);

  // Next state.
  always_comb begin
    nxt          = cur;
    nxt.phase    = phase_next;
    nxt.six_mode = flag_n;
    nxt.accum    = accum_n;
    if (done) begin
      nxt.accum = '0;
      nxt.prev  = accum_n;
      if (arrow_jp != '0) begin
        nxt.arrow_last = arrow_hi;
        nxt.arrow_time = now_ms;
      end else if (arrow_hit) begin
        nxt.arrow_time = now_ms;
      end
      if (action_jp != '0) begin
        nxt.action_last = action_hi;
        nxt.action_time = now_ms;
      end else if (action_hit) begin
        nxt.action_time = now_ms;
      end
    end
  end

  // The button fields are zero unless this sample ends a poll.
  always_comb begin
    res.select_level   = phase_bits[0];
    res.poll_done      = done;
    res.buttons        = done ? accum_n : '0;
    res.changed        = done && (accum_n != cur.prev);
    res.just_pressed   = done ? jp : '0;
    res.repeat_pressed = rp;
    res.six_mode       = flag_n;
  end

endmodule

// ===== src/six_button_pad_poller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_button_pad_poller_core: select-line sequencer and button decoder
// Top level with the pin sample channel, the result channel and the
// register port for the auto-repeat hold times.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one settled sample of the
//   six active-low pad pins with its millisecond time. Every sample yields
//   exactly one result transaction on the output channel (out_valid/
//   out_stall). Drive select_level of each result on the pad before taking
//   the next sample. poll_done marks the result that ends a poll; only then
//   are buttons, changed, just_pressed and repeat_pressed nonzero.
//   An accepted sample's result is registered in the output buffer. One
//   sample is taken every cycle while the receiver keeps up; the only limit
//   is the registered state update of the sequencer. A two-entry output
//   buffer takes the sample that arrives while the receiver stalls;
//   in_stall is high while both entries are full. Reset returns to
//   three-button mode at the select-low phase with no buttons held, empties
//   the buffer and loads hold times of 80 ms for arrows and 150 ms for
//   action buttons. Hold-time registers lie at byte addresses 0 (arrows)
//   and 4 (actions); write them only while idle.
// ----------------------------------------------------------------------------
module six_button_pad_poller_core (
  input  logic        clk,
  input  logic        rst,
  // Sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  pin_levels,
  input  logic [31:0] now_ms,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        select_level,
  output logic        poll_done,
  output logic [11:0] buttons,
  output logic        changed,
  output logic [11:0] just_pressed,
  output logic [11:0] repeat_pressed,
  output logic        six_mode,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam sbpp_pkg::state_t STATE_RST = '{
    phase:       sbpp_pkg::PH_LOW0,
    accum:       '0,
    six_mode:    1'b0,
    prev:        '0,
    arrow_last:  sbpp_pkg::NONE_IDX,
    arrow_time:  '0,
    action_last: sbpp_pkg::NONE_IDX,
    action_time: '0
  };

  logic [15:0]        arrow_repeat_ms;
  logic [15:0]        action_repeat_ms;
  logic               cfg_write;
  logic               in_accept;
  sbpp_pkg::state_t   state;
  sbpp_pkg::state_t   state_next;
  sbpp_pkg::result_t  step_res;
  sbpp_pkg::result_t  out_data;
  sbpp_pkg::result_t  skid_data;
  logic               skid_valid;

  // Register port: never inserts wait states, writes on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrow_repeat_ms  <= sbpp_pkg::ARROW_REPEAT_RST;
      action_repeat_ms <= sbpp_pkg::ACTION_REPEAT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        sbpp_pkg::REG_ARROW_REPEAT:  arrow_repeat_ms  <= pwdata[15:0];
        sbpp_pkg::REG_ACTION_REPEAT: action_repeat_ms <= pwdata[15:0];
        default:                     arrow_repeat_ms  <= arrow_repeat_ms;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sbpp_pkg::REG_ARROW_REPEAT:  prdata = {16'b0, arrow_repeat_ms};
      sbpp_pkg::REG_ACTION_REPEAT: prdata = {16'b0, action_repeat_ms};
      default:                     prdata = '0;
    endcase
  end

  // A sample is taken whenever the spare output entry is free.
  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;

  sbpp_step u_step (
    .pin_levels       (pin_levels),
    .now_ms           (now_ms),
    .arrow_repeat_ms  (arrow_repeat_ms),
    .action_repeat_ms (action_repeat_ms),
    .cur              (state),
    .nxt              (state_next),
    .res              (step_res)
  );

  // Sequencer state advances once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output buffer control: main entry plus one spare entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_data <= step_res;
      end else begin
        out_data <= step_res;
      end
    end else if (out_valid && !out_stall && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign select_level   = out_data.select_level;
  assign poll_done      = out_data.poll_done;
  assign buttons        = out_data.buttons;
  assign changed        = out_data.changed;
  assign just_pressed   = out_data.just_pressed;
  assign repeat_pressed = out_data.repeat_pressed;
  assign six_mode       = out_data.six_mode;

endmodule

// ===== src/sbpp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpp_checker: port-level checks for the six-button pad poller
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module sbpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        select_level,
  input logic        poll_done,
  input logic [11:0] buttons,
  input logic        changed,
  input logic [11:0] just_pressed,
  input logic [11:0] repeat_pressed
);

  // Results that do not end a poll carry no button information.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !poll_done) |->
      (buttons == '0 && just_pressed == '0 && repeat_pressed == '0 && !changed))
    else $error("button fields set on a result that does not end a poll");

  // A finished poll always restarts with select driven low.
  a_done_select_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && poll_done) |-> !select_level)
    else $error("poll ended without returning select low");

  // Edge and repeat bits are held buttons, and a button never does both.
  a_bits_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((just_pressed & ~buttons) == '0 &&
                   (repeat_pressed & ~buttons) == '0 &&
                   (repeat_pressed & just_pressed) == '0))
    else $error("just_pressed or repeat_pressed inconsistent with buttons");

  // A stalled result transaction holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(buttons) && $stable(poll_done) && $stable(select_level)))
    else $error("result changed while stalled");

endmodule

bind six_button_pad_poller_core sbpp_checker u_sbpp_checker (.*);
